// ===== rtl/bpfl_pkg.sv =====
// Package: shared constants, types and helpers of the block pool free list.
`default_nettype none
package bpfl_pkg;

	localparam int MAX_BLOCKS  = 256;
	localparam int OFFSET_BITS = 24;
	localparam int ID_W        = $clog2(MAX_BLOCKS);
	localparam int COUNT_W     = 9;
	localparam int BYTES_W     = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;

	localparam logic [COUNT_W-1:0] RESET_COUNT = COUNT_W'(256);
	localparam logic [BYTES_W-1:0] RESET_BYTES = BYTES_W'(4096);
	localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(MAX_BLOCKS);
	localparam logic [BYTES_W-1:0] BYTES_MAX   = BYTES_W'(65536);

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = CFG_IDX_W'(1);

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_INVALID = 2'd2,
		STAT_FULL    = 2'd3
	} bpfl_status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_DIV
	} bpfl_state_t;

	typedef struct packed {
		logic                   kind;
		logic [OFFSET_BITS-1:0] free_offset;
	} bpfl_req_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] block_offset;
		bpfl_status_t           status;
		logic [COUNT_W-1:0]     free_count;
	} bpfl_rsp_t;

	typedef struct packed {
		logic            rd_en;
		logic [ID_W-1:0] rd_addr;
		logic            wr_en;
		logic [ID_W-1:0] wr_addr;
		logic [ID_W-1:0] wr_data;
		logic            clr;
	} bpfl_stk_cmd_t;

	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] r;
		r = c;
		if (c == '0) r = COUNT_W'(1);
		if (c > COUNT_MAX) r = COUNT_MAX;
		return r;
	endfunction

	function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] b);
		logic [BYTES_W-1:0] r;
		r = b;
		if (b == '0) r = BYTES_W'(1);
		if (b > BYTES_MAX) r = BYTES_MAX;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bpfl_stack.sv =====
// Free stack memory with per-entry valid bits; an unwritten entry reads as its index.
`default_nettype none
module bpfl_stack (
	input  wire                      clk,
	input  wire                      arst_n,
	input  bpfl_pkg::bpfl_stk_cmd_t  cmd,
	output logic [bpfl_pkg::ID_W-1:0] rd_data
);
	import bpfl_pkg::*;

	logic [ID_W-1:0]       mem [MAX_BLOCKS];
	logic [MAX_BLOCKS-1:0] valid_q;
	logic [ID_W-1:0]       mem_rd_q;
	logic [ID_W-1:0]       addr_q;
	logic                  vld_q;

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= cmd.wr_data;
		end
		if (cmd.rd_en) begin
			mem_rd_q <= mem[cmd.rd_addr];
			addr_q   <= cmd.rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (cmd.clr) begin
				valid_q <= '0;
			end else if (cmd.wr_en) begin
				valid_q[cmd.wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				vld_q <= valid_q[cmd.rd_addr];
			end
		end
	end

	assign rd_data = vld_q ? mem_rd_q : addr_q;

endmodule
`default_nettype wire

// ===== rtl/bpfl_mul.sv =====
// Shift-add multiplier: block number times block size, one multiplier bit per cycle.
`default_nettype none
module bpfl_mul (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [bpfl_pkg::ID_W-1:0]        id,
	input  wire  [bpfl_pkg::BYTES_W-1:0]     size,
	output logic                             done,
	output logic [bpfl_pkg::OFFSET_BITS-1:0] prod
);
	import bpfl_pkg::*;

	localparam int CNT_W = $clog2(ID_W + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(ID_W - 1);

	logic [BYTES_W-1:0] acc_q;
	logic [ID_W-1:0]    mq_q;
	logic [BYTES_W-1:0] size_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;
	logic [BYTES_W:0]   sum;
	logic [BYTES_W+ID_W-1:0] full;

	// acc never exceeds size, so the sum fits one extra bit
	assign sum  = {1'b0, acc_q} + (mq_q[0] ? {1'b0, size_q} : '0);
	assign full = {acc_q, mq_q};

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mq_q   <= id;
			size_q <= size;
		end else if (run_q) begin
			acc_q <= sum[BYTES_W:1];
			mq_q  <= {sum[0], mq_q[ID_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = full[OFFSET_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/bpfl_div.sv =====
// Restoring divider: offset by block size, one quotient bit per cycle.
`default_nettype none
module bpfl_div (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire  [bpfl_pkg::OFFSET_BITS-1:0] dividend,
	input  wire  [bpfl_pkg::BYTES_W-1:0]     divisor,
	output logic                             done,
	output logic [bpfl_pkg::OFFSET_BITS-1:0] quot,
	output logic [bpfl_pkg::BYTES_W-1:0]     rem
);
	import bpfl_pkg::*;

	localparam int CNT_W = $clog2(OFFSET_BITS + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(OFFSET_BITS - 1);

	logic [BYTES_W-1:0]     rem_q;
	logic [OFFSET_BITS-1:0] quo_q;
	logic [BYTES_W-1:0]     dvs_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   run_q;
	logic                   done_q;
	logic [BYTES_W:0]       trial;
	logic [BYTES_W:0]       diff;
	logic                   ge;

	// quo_q shifts the dividend out at the top and quotient bits in at the bottom
	assign trial = {rem_q, quo_q[OFFSET_BITS-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[BYTES_W-1:0] : trial[BYTES_W-1:0];
			quo_q <= {quo_q[OFFSET_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/block_pool_free_list_unit.sv =====
// Top level: fixed-size block allocator with a LIFO free stack.
//
// Items enter on start/req when busy is low. Each item gives exactly one
// result on rsp, marked by a one-cycle done strobe; the receiver takes it
// on that cycle and cannot stall it.
// Allocate pops the top block number and multiplies it by the block size in
// a shift-add unit (one bit of the block number per cycle); the product is
// registered with the done strobe once the unit finishes.
// Allocate on an empty pool answers the next cycle. Free runs a restoring
// divider, one quotient bit per cycle over the 24 offset bits, and its
// result is registered with the done strobe once the divider finishes.
// Busy is low while the strobe is shown, so the next item may be accepted at
// the edge that takes the result. An allocate on an empty pool never raises
// busy, giving one allocate on an empty pool per cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; ready is
// always high. Index 0 is block_count, 1 is block_bytes, others ignored.
// Any accepted write to either register reloads the stack to 0..count-1.
// Reset loads 256 blocks of 4096 bytes with a full stack; the stack memory
// needs no clearing pass since per-entry valid bits clear at once.
`default_nettype none
module block_pool_free_list_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  bpfl_pkg::bpfl_req_t                  req,
	output logic                                 done,
	output bpfl_pkg::bpfl_rsp_t                  rsp,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [bpfl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [bpfl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bpfl_pkg::*;

	bpfl_state_t        state_q, state_d;
	logic [COUNT_W-1:0] count_cfg_q;
	logic [BYTES_W-1:0] bytes_cfg_q;
	logic [COUNT_W-1:0] depth_q, depth_d;
	bpfl_rsp_t          rsp_q, rsp_d;
	logic               done_q, done_d;

	logic [COUNT_W-1:0] count_eff;
	logic [BYTES_W-1:0] bytes_eff;
	logic               accept;
	logic               cfg_wr;
	logic               reload;
	logic [COUNT_W-1:0] reload_depth;

	bpfl_stk_cmd_t          stk_cmd;
	logic [ID_W-1:0]        stk_rd_data;
	logic                   mul_start, mul_done;
	logic [OFFSET_BITS-1:0] mul_prod;
	logic                   div_start, div_done;
	logic [OFFSET_BITS-1:0] div_quot;
	logic [BYTES_W-1:0]     div_rem;
	logic                   free_bad;

	assign count_eff = eff_count(count_cfg_q);
	assign bytes_eff = eff_bytes(bytes_cfg_q);
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_comb begin
		reload       = 1'b0;
		reload_depth = count_eff;
		unique case (cfg_index)
			CFG_BLOCK_COUNT: begin
				reload       = cfg_wr;
				reload_depth = eff_count(cfg_data[COUNT_W-1:0]);
			end
			CFG_BLOCK_BYTES: begin
				reload = cfg_wr;
			end
			default: begin
				reload = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= RESET_COUNT;
			bytes_cfg_q <= RESET_BYTES;
		end else if (cfg_wr) begin
			if (cfg_index == CFG_BLOCK_COUNT) count_cfg_q <= cfg_data[COUNT_W-1:0];
			if (cfg_index == CFG_BLOCK_BYTES) bytes_cfg_q <= cfg_data[BYTES_W-1:0];
		end
	end

	// range test by quotient: offset >= count*size exactly when offset/size >= count
	assign free_bad = (div_quot >= OFFSET_BITS'(count_eff)) || (div_rem != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_FREE) state_d = ST_DIV;
					else if (depth_q != '0) state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_MUL;
			ST_MUL:  if (mul_done) state_d = ST_IDLE;
			ST_DIV:  if (div_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		stk_cmd           = '0;
		mul_start         = 1'b0;
		div_start         = 1'b0;
		depth_d           = depth_q;
		done_d            = 1'b0;
		rsp_d             = rsp_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_FREE) begin
						div_start = 1'b1;
					end else if (depth_q == '0) begin
						done_d             = 1'b1;
						rsp_d.block_offset = '0;
						rsp_d.status       = STAT_EMPTY;
						rsp_d.free_count   = depth_q;
					end else begin
						stk_cmd.rd_en   = 1'b1;
						stk_cmd.rd_addr = ID_W'(depth_q - COUNT_W'(1));
						depth_d         = depth_q - COUNT_W'(1);
					end
				end
			end
			ST_READ: begin
				mul_start = 1'b1;
			end
			ST_MUL: begin
				if (mul_done) begin
					done_d             = 1'b1;
					rsp_d.block_offset = mul_prod;
					rsp_d.status       = STAT_OK;
					rsp_d.free_count   = depth_q;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					done_d             = 1'b1;
					rsp_d.block_offset = '0;
					rsp_d.free_count   = depth_q;
					if (free_bad) begin
						rsp_d.status = STAT_INVALID;
					end else if (depth_q >= count_eff) begin
						rsp_d.status = STAT_FULL;
					end else begin
						stk_cmd.wr_en    = 1'b1;
						stk_cmd.wr_addr  = depth_q[ID_W-1:0];
						stk_cmd.wr_data  = div_quot[ID_W-1:0];
						depth_d          = depth_q + COUNT_W'(1);
						rsp_d.status     = STAT_OK;
						rsp_d.free_count = depth_q + COUNT_W'(1);
					end
				end
			end
			default: begin
				done_d = 1'b0;
			end
		endcase
		stk_cmd.clr = reload;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= RESET_COUNT;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			depth_q <= reload ? reload_depth : depth_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	bpfl_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (stk_cmd),
		.rd_data (stk_rd_data)
	);

	bpfl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.id     (stk_rd_data),
		.size   (bytes_eff),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	bpfl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.free_offset),
		.divisor  (bytes_eff),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/bpfl_checker.sv =====
// Port-level checker for the block pool free list, bound to the top level.
`default_nettype none
module bpfl_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             start,
	input wire                             busy,
	input bpfl_pkg::bpfl_req_t             req,
	input wire                             done,
	input bpfl_pkg::bpfl_rsp_t             rsp,
	input wire                             cfg_valid,
	input wire                             cfg_ready,
	input wire [bpfl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input wire [bpfl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import bpfl_pkg::*;

	// an accepted item either keeps the block busy or answers at once
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted item neither busy nor answered");

	// failed items never carry an offset
	a_fail_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status != STAT_OK |-> rsp.block_offset == '0)
		else $error("failed item with nonzero offset");

	// empty is only reported with no free blocks left
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == STAT_EMPTY |-> rsp.free_count == '0)
		else $error("empty status with free blocks");

	// no result without work in flight the cycle before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) || $past(start))
		else $error("result without an item");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.free_count <= COUNT_MAX)
		else $error("free count above pool size");

endmodule

bind block_pool_free_list_unit bpfl_checker u_bpfl_checker (.*);
`default_nettype wire
